@@ rtl/nlp_pkg.sv @@
// Shared types, character codes and helpers for the numeric literal parser.
// No dependencies; every other file in rtl/ imports this package.
package nlp_pkg;

  localparam int VAL_W      = 64;
  localparam int EXT_W      = VAL_W + 4;
  localparam int CHAR_W     = 8;
  localparam int RADIX_W    = 5;
  localparam int DIGIT_W    = 4;
  localparam int NUM_BASES  = 4;
  localparam int OUT_DATA_W = 80;
  localparam int OUT_PAD_W  = OUT_DATA_W - (VAL_W + RADIX_W + 3 + 1 + 1);

  localparam logic [CHAR_W-1:0] CH_NUL    = 8'h00;
  localparam logic [CHAR_W-1:0] CH_DOT    = 8'h2e;
  localparam logic [CHAR_W-1:0] CH_0      = 8'h30;
  localparam logic [CHAR_W-1:0] CH_9      = 8'h39;
  localparam logic [CHAR_W-1:0] CH_UP_A   = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UP_Z   = 8'h5a;
  localparam logic [CHAR_W-1:0] CH_USCORE = 8'h5f;
  localparam logic [CHAR_W-1:0] CH_A      = 8'h61;
  localparam logic [CHAR_W-1:0] CH_B      = 8'h62;
  localparam logic [CHAR_W-1:0] CH_D      = 8'h64;
  localparam logic [CHAR_W-1:0] CH_E      = 8'h65;
  localparam logic [CHAR_W-1:0] CH_F      = 8'h66;
  localparam logic [CHAR_W-1:0] CH_H      = 8'h68;
  localparam logic [CHAR_W-1:0] CH_O      = 8'h6f;
  localparam logic [CHAR_W-1:0] CH_Q      = 8'h71;
  localparam logic [CHAR_W-1:0] CH_T      = 8'h74;
  localparam logic [CHAR_W-1:0] CH_X      = 8'h78;
  localparam logic [CHAR_W-1:0] CH_Y      = 8'h79;
  localparam logic [CHAR_W-1:0] CH_Z      = 8'h7a;

  typedef enum logic [1:0] {PH_IDLE, PH_ZERO, PH_PLAIN, PH_PREFIXED} phase_t;
  typedef enum logic [1:0] {RAD_DEC, RAD_BIN, RAD_OCT, RAD_HEX} rad_t;
  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_BADBASE  = 3'd1,
    ST_BIGDIGIT = 3'd2,
    ST_FLOAT    = 3'd3,
    ST_NOTLIT   = 3'd4
  } status_t;

  typedef logic [VAL_W-1:0] value_t;
  typedef value_t [NUM_BASES-1:0] acc_vec_t;

  typedef struct packed {
    logic               clear;
    logic               add;
    logic [DIGIT_W-1:0] digit;
  } acc_cmd_t;

  typedef struct packed {
    logic               consumed;
    logic               ovf;
    status_t            status;
    logic [RADIX_W-1:0] radix;
    value_t             value;
  } result_t;

  function automatic logic [RADIX_W-1:0] radix_of(input rad_t code);
    logic [RADIX_W-1:0] r;
    unique case (code)
      RAD_DEC: r = RADIX_W'(10);
      RAD_BIN: r = RADIX_W'(2);
      RAD_OCT: r = RADIX_W'(8);
      RAD_HEX: r = RADIX_W'(16);
      default: r = RADIX_W'(10);
    endcase
    return r;
  endfunction

endpackage

@@ rtl/nlp_acc.sv @@
// Four running accumulators (bases 10, 2, 8, 16), their overflow bits and
// the largest digit seen. Depends on nlp_pkg.
module nlp_acc (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  nlp_pkg::acc_cmd_t cmd,
  output nlp_pkg::acc_vec_t acc,
  output logic [3:0]        ovf_flags,
  output logic [3:0]        largest_digit
);
  import nlp_pkg::*;

  acc_vec_t   acc_r, acc_nxt;
  logic [3:0] ovf_r, ovf_nxt;
  logic [DIGIT_W-1:0] big_r, big_nxt;

  always_comb begin
    logic [EXT_W-1:0] ext;
    logic [EXT_W-1:0] prod;
    value_t           base;
    logic [3:0]       ovf_base;
    logic [DIGIT_W-1:0] big_base;
    ovf_base = cmd.clear ? 4'd0 : ovf_r;
    big_base = cmd.clear ? '0 : big_r;
    acc_nxt  = acc_r;
    ovf_nxt  = ovf_base;
    big_nxt  = big_base;
    for (int k = 0; k < NUM_BASES; k++) begin
      base = cmd.clear ? '0 : acc_r[k];
      ext  = {4'd0, base};
      unique case (rad_t'(k))
        RAD_DEC: prod = (ext << 3) + (ext << 1);
        RAD_BIN: prod = ext << 1;
        RAD_OCT: prod = ext << 3;
        RAD_HEX: prod = ext << 4;
        default: prod = ext;
      endcase
      prod = prod + EXT_W'(cmd.digit);
      if (cmd.add) begin
        acc_nxt[k] = prod[VAL_W-1:0];
        ovf_nxt[k] = ovf_base[k] | (|prod[EXT_W-1:VAL_W]);
      end else begin
        acc_nxt[k] = base;
      end
    end
    if (cmd.add && cmd.digit > big_base) begin
      big_nxt = cmd.digit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
      ovf_r <= '0;
      big_r <= '0;
    end else if (step) begin
      acc_r <= acc_nxt;
      ovf_r <= ovf_nxt;
      big_r <= big_nxt;
    end
  end

  assign acc           = acc_r;
  assign ovf_flags     = ovf_r;
  assign largest_digit = big_r;

endmodule

@@ rtl/nlp_ctrl.sv @@
// Parse phase machine: classifies each character, steers the accumulators
// and forms the result word when a literal ends. Depends on nlp_pkg.
module nlp_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        step,
  input  logic [nlp_pkg::CHAR_W-1:0]  ch,
  input  nlp_pkg::acc_vec_t           acc,
  input  logic [3:0]                  ovf_flags,
  input  logic [3:0]                  largest_digit,
  output nlp_pkg::acc_cmd_t           cmd,
  output logic                        res_vld,
  output nlp_pkg::result_t            res,
  output nlp_pkg::phase_t             phase
);
  import nlp_pkg::*;

  phase_t phase_r, phase_nxt;
  rad_t   prad_r, prad_nxt;

  logic               is_dec, is_hexl, is_lower, is_letter;
  logic [DIGIT_W-1:0] dig;

  assign is_dec    = (ch >= CH_0) && (ch <= CH_9);
  assign is_hexl   = (ch >= CH_A) && (ch <= CH_F);
  assign is_lower  = (ch >= CH_A) && (ch <= CH_Z);
  assign is_letter = is_lower || ((ch >= CH_UP_A) && (ch <= CH_UP_Z));
  assign dig       = is_dec  ? ch[3:0] :
                     is_hexl ? DIGIT_W'(ch[3:0] + 4'd9) : '0;

  always_comb begin
    logic    fin, fin_use, fin_cons, pvalid;
    rad_t    fin_code, sfx;
    status_t fin_st;
    fin       = 1'b0;
    fin_use   = 1'b0;
    fin_cons  = 1'b0;
    fin_code  = RAD_DEC;
    fin_st    = ST_OK;
    sfx       = RAD_DEC;
    pvalid    = 1'b0;
    phase_nxt = phase_r;
    prad_nxt  = prad_r;
    cmd       = '{clear: 1'b0, add: 1'b0, digit: dig};

    unique case (phase_r)
      PH_ZERO: begin
        if (ch == CH_B || ch == CH_Y || ch == CH_O || ch == CH_Q ||
            ch == CH_X || ch == CH_H || ch == CH_D || ch == CH_T) begin
          prad_nxt  = (ch == CH_B || ch == CH_Y) ? RAD_BIN :
                      (ch == CH_O || ch == CH_Q) ? RAD_OCT :
                      (ch == CH_X || ch == CH_H) ? RAD_HEX : RAD_DEC;
          phase_nxt = PH_PREFIXED;
        end else if (is_dec) begin
          cmd.add   = 1'b1;
          phase_nxt = PH_PLAIN;
        end else if (ch == CH_USCORE) begin
          phase_nxt = PH_PLAIN;
        end else if (ch == CH_DOT) begin
          fin = 1'b1; fin_st = ST_FLOAT; fin_cons = 1'b1;
        end else if (is_letter && ch != CH_E) begin
          fin = 1'b1; fin_st = ST_BADBASE; fin_cons = 1'b1;
        end else begin
          fin = 1'b1; fin_use = 1'b1;
        end
      end
      PH_PLAIN: begin
        if (is_dec) begin
          cmd.add = 1'b1;
        end else if (ch == CH_USCORE) begin
          fin = 1'b0;
        end else if (ch == CH_DOT) begin
          fin = 1'b1; fin_st = ST_FLOAT; fin_cons = 1'b1;
        end else if (ch == CH_B || ch == CH_O || ch == CH_H) begin
          sfx      = (ch == CH_B) ? RAD_BIN : (ch == CH_O) ? RAD_OCT : RAD_HEX;
          fin      = 1'b1;
          fin_code = sfx;
          fin_cons = 1'b1;
          if (RADIX_W'(largest_digit) >= radix_of(sfx)) begin
            fin_st = ST_BIGDIGIT;
          end else begin
            fin_use = 1'b1;
          end
        end else begin
          fin = 1'b1; fin_use = 1'b1;
        end
      end
      PH_PREFIXED: begin
        fin_code = prad_r;
        pvalid   = (is_dec || (prad_r == RAD_HEX && is_hexl)) &&
                   (RADIX_W'(dig) < radix_of(prad_r));
        if (pvalid) begin
          cmd.add = 1'b1;
        end else if (ch == CH_USCORE) begin
          fin = 1'b0;
        end else if (ch == CH_DOT) begin
          fin = 1'b1; fin_st = ST_FLOAT; fin_cons = 1'b1;
        end else begin
          fin = 1'b1; fin_use = 1'b1;
        end
      end
      default: begin
        cmd.clear = 1'b1;
        prad_nxt  = RAD_DEC;
        if (ch == CH_0) begin
          phase_nxt = PH_ZERO;
        end else if (is_dec) begin
          cmd.add   = 1'b1;
          phase_nxt = PH_PLAIN;
        end else begin
          fin = 1'b1; fin_st = ST_NOTLIT;
        end
      end
    endcase

    if (fin) begin
      cmd.clear = 1'b1;
      phase_nxt = PH_IDLE;
      prad_nxt  = RAD_DEC;
    end

    res_vld      = fin;
    res.value    = fin_use ? acc[fin_code] : '0;
    res.radix    = radix_of(fin_code);
    res.status   = fin_st;
    res.ovf      = fin_use & ovf_flags[fin_code];
    res.consumed = fin_cons;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      prad_r  <= RAD_DEC;
    end else if (step) begin
      phase_r <= phase_nxt;
      prad_r  <= prad_nxt;
    end
  end

  assign phase = phase_r;

endmodule

@@ rtl/numeric_literal_parser.sv @@
// Parses an assembler integer literal, one character word per cycle: radix
// prefixes 0b/0y, 0o/0q, 0x/0h, 0d/0t, suffixes b/o/h, underscore skipping,
// one result word when the literal ends. A character word is taken into an
// input register and processed from there through the phase machine and
// the four shift-add accumulators into the output register, so one
// character is accepted every cycle unless a held result stalls the input.
// A result word is registered in the output register when its ending
// character is processed from the input register, and is presented from
// there. While out_tready is low and a result word waits in the output
// register, the next character waits in the input register, whether or
// not it ends a literal, and the input stalls behind it. Code 0 marks end
// of text. Depends on nlp_pkg, nlp_acc and nlp_ctrl.
module numeric_literal_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] char_code
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [79:0] out_tdata   // [63:0] literal_value, [68:64] radix_used,
                                  // [71:69] parse_status, [72] overflow_flag,
                                  // [73] stop_consumed, [79:74] zero
);
  import nlp_pkg::*;

  logic              in_vld_r, in_vld_nxt;
  logic [CHAR_W-1:0] ch_r;
  logic              out_vld_r, out_vld_nxt;
  result_t           out_res_r;

  logic       proc_fire, in_fire;
  acc_cmd_t   cmd;
  acc_vec_t   acc;
  logic [3:0] ovf_flags;
  logic [3:0] largest_digit;
  logic       res_vld;
  result_t    res;
  phase_t     phase;

  assign proc_fire = in_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !in_vld_r || proc_fire;
  assign in_fire   = in_tvalid && in_tready;

  nlp_acc u_acc (
    .clk           (clk),
    .rst_n         (rst_n),
    .step          (proc_fire),
    .cmd           (cmd),
    .acc           (acc),
    .ovf_flags     (ovf_flags),
    .largest_digit (largest_digit)
  );

  nlp_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .step          (proc_fire),
    .ch            (ch_r),
    .acc           (acc),
    .ovf_flags     (ovf_flags),
    .largest_digit (largest_digit),
    .cmd           (cmd),
    .res_vld       (res_vld),
    .res           (res),
    .phase         (phase)
  );

  always_comb begin
    in_vld_nxt = in_fire ? 1'b1 : (proc_fire ? 1'b0 : in_vld_r);
    if (proc_fire && res_vld) begin
      out_vld_nxt = 1'b1;
    end else if (out_tready) begin
      out_vld_nxt = 1'b0;
    end else begin
      out_vld_nxt = out_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      ch_r <= in_tdata;
    end
    if (proc_fire && res_vld) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {{OUT_PAD_W{1'b0}}, out_res_r.consumed, out_res_r.ovf,
                       out_res_r.status, out_res_r.radix, out_res_r.value};

`ifndef SYNTH
  a_full_input_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_vld_r) |-> proc_fire)
    else $error("input register overwritten before processing");

  a_result_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (proc_fire && res_vld) |=> (phase == PH_IDLE))
    else $error("parser not idle after a result");

  a_notlit_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_res_r.status == ST_NOTLIT) |->
    (out_res_r.value == '0 && !out_res_r.consumed && !out_res_r.ovf))
    else $error("non-literal result carries data");

  a_bigdigit_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_res_r.status == ST_BIGDIGIT) |->
    (out_res_r.value == '0 && !out_res_r.ovf && out_res_r.consumed))
    else $error("oversized digit result carries a value");
`endif

endmodule
